@@ hdl/cordic_sine_cosine_assert.svh @@
// assertion macros for the cordic sine and cosine block
// used by the checker module only, no other dependencies
`ifndef CORDIC_SINE_COSINE_ASSERT_SVH
`define CORDIC_SINE_COSINE_ASSERT_SVH

// implication in the same cycle
`define CSC_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("cordic_sine_cosine check failed");

// implication in the next cycle
`define CSC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("cordic_sine_cosine check failed");

`endif

@@ hdl/csc_pkg.sv @@
// shared types and constants of the cordic sine and cosine block
// no dependencies
package csc_pkg;

   localparam int ANGLE_WIDTH  = 20;
   localparam int RESULT_WIDTH = 18;
   localparam int WORK_BITS    = 30;
   localparam int TABLE_LEN    = 25;
   localparam int CW           = 34;

   localparam logic signed [63:0] Q_PI      = 64'sd3373259426;
   localparam logic signed [63:0] Q_HALF_PI = 64'sd1686629713;
   localparam logic signed [63:0] Q_TWO_PI  = 64'sd6746518852;
   localparam logic signed [63:0] Q_GAIN    = 64'sd652032874;

   // atan(2^-i) in q2.30
   localparam logic signed [63:0] ATAN_Q30 [TABLE_LEN] = '{
      64'sd843314857, 64'sd497837829, 64'sd263043837, 64'sd133525159,
      64'sd67021687,  64'sd33543516,  64'sd16775851,  64'sd8388437,
      64'sd4194283,   64'sd2097149,   64'sd1048576,   64'sd524288,
      64'sd262144,    64'sd131072,    64'sd65536,     64'sd32768,
      64'sd16384,     64'sd8192,      64'sd4096,      64'sd2048,
      64'sd1024,      64'sd512,       64'sd256,       64'sd128,
      64'sd64
   };

   typedef struct packed {
      logic              flip;
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic signed [CW-1:0] z;
   } csc_stage_type;

endpackage

@@ hdl/csc_reduce.sv @@
// angle conversion to q2.30, wrap into [-pi, pi] and fold into [-pi/2, pi/2]
// depends on csc_pkg
module csc_reduce #(
   parameter int FRAC_BITS = 16
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       in_valid,
   input  logic signed [csc_pkg::ANGLE_WIDTH-1:0]     in_angle,
   output logic                                       in_hold,
   output logic                                       out_valid,
   output csc_pkg::csc_stage_type                     out_stage,
   input  logic                                       out_hold
);
   import csc_pkg::*;

   localparam int SHIFT = WORK_BITS - FRAC_BITS;
   localparam int WB    = (FRAC_BITS >= 16) ? 1 : 17 - FRAC_BITS;
   localparam int NW    = 2 * WB;
   localparam int AW    = (FRAC_BITS > 18) ? 36 : 54 - FRAC_BITS;

   localparam logic signed [AW-1:0] PI_W     = AW'(Q_PI);
   localparam logic signed [AW-1:0] NEG_PI_W = AW'(-Q_PI);
   localparam logic signed [CW-1:0] PI_C     = CW'(Q_PI);
   localparam logic signed [CW-1:0] HPI_C    = CW'(Q_HALF_PI);

   logic signed [AW-1:0] a_src [NW];
   logic signed [AW-1:0] a_in  [NW];
   logic signed [AW-1:0] a_ff  [NW];
   logic                 v_src [NW];
   logic                 v_ff  [NW];
   logic                 busy  [NW];
   logic                 fold_busy;

   logic                 fv_ff;
   csc_stage_type        fstage_ff;
   csc_stage_type        fstage_in;
   logic signed [CW-1:0] za;

   assign a_src[0] = AW'(in_angle) <<< SHIFT;
   assign v_src[0] = in_valid;
   assign in_hold  = busy[0];

   genvar k;
   generate
      for (k = 0; k < NW; k++) begin : g_wrap
         localparam int J = (k < WB) ? WB - 1 - k : NW - 1 - k;
         localparam logic SUB = (k < WB);
         localparam logic signed [AW-1:0] STEP = AW'(Q_TWO_PI <<< J);
         logic signed [AW-1:0] cand;
         logic                 take;

         if (k > 0) begin : g_link
            assign a_src[k] = a_ff[k-1];
            assign v_src[k] = v_ff[k-1];
         end

         if (k == NW - 1) begin : g_last
            assign busy[k] = v_ff[k] && fold_busy;
         end else begin : g_mid
            assign busy[k] = v_ff[k] && busy[k+1];
         end

         always_comb begin
            if (SUB) begin
               cand = a_src[k] - STEP;
               take = cand > NEG_PI_W;
            end else begin
               cand = a_src[k] + STEP;
               take = cand < PI_W;
            end
            a_in[k] = take ? cand : a_src[k];
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               v_ff[k] <= 1'b0;
            end else if (!busy[k]) begin
               v_ff[k] <= v_src[k];
            end
         end

         always_ff @(posedge clock) begin
            if (!busy[k]) begin
               a_ff[k] <= a_in[k];
            end
         end
      end
   endgenerate

   // fold into [-pi/2, pi/2]
   always_comb begin
      za             = $signed(a_ff[NW-1][CW-1:0]);
      fstage_in.x    = CW'(Q_GAIN);
      fstage_in.y    = '0;
      fstage_in.z    = za;
      fstage_in.flip = 1'b0;
      if (za > HPI_C) begin
         fstage_in.z    = PI_C - za;
         fstage_in.flip = 1'b1;
      end else if (za < -HPI_C) begin
         fstage_in.z    = -PI_C - za;
         fstage_in.flip = 1'b1;
      end
   end

   assign fold_busy = fv_ff && out_hold;

   always_ff @(posedge clock) begin
      if (reset) begin
         fv_ff <= 1'b0;
      end else if (!fold_busy) begin
         fv_ff <= v_ff[NW-1];
      end
   end

   always_ff @(posedge clock) begin
      if (!fold_busy) begin
         fstage_ff <= fstage_in;
      end
   end

   assign out_valid = fv_ff;
   assign out_stage = fstage_ff;

endmodule

@@ hdl/csc_cell.sv @@
// one cordic rotation step with its pipeline register
// depends on csc_pkg
module csc_cell #(
   parameter int STAGE = 0
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  csc_pkg::csc_stage_type in_stage,
   output logic                   in_hold,
   output logic                   out_valid,
   output csc_pkg::csc_stage_type out_stage,
   input  logic                   out_hold
);
   import csc_pkg::*;

   localparam logic signed [CW-1:0] ATAN_C = CW'(ATAN_Q30[STAGE]);

   logic                 valid_ff;
   csc_stage_type        stage_ff;
   csc_stage_type        stage_in;
   logic signed [CW-1:0] dx;
   logic signed [CW-1:0] dy;
   logic                 busy;

   assign busy = valid_ff && out_hold;

   always_comb begin
      dx            = in_stage.y >>> STAGE;
      dy            = in_stage.x >>> STAGE;
      stage_in.flip = in_stage.flip;
      if (in_stage.z > 0) begin
         stage_in.x = in_stage.x - dx;
         stage_in.y = in_stage.y + dy;
         stage_in.z = in_stage.z - ATAN_C;
      end else begin
         stage_in.x = in_stage.x + dx;
         stage_in.y = in_stage.y - dy;
         stage_in.z = in_stage.z + ATAN_C;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!busy) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!busy) begin
         stage_ff <= stage_in;
      end
   end

   assign in_hold   = busy;
   assign out_valid = valid_ff;
   assign out_stage = stage_ff;

endmodule

@@ hdl/cordic_sine_cosine.sv @@
// top level of the pipelined cordic sine and cosine block
// depends on csc_pkg, csc_reduce and csc_cell
//
// req channel: req_valid with req_angle, signed radians with FRAC_BITS
// fraction bits; req_stall high means the transfer is not taken.
// rsp channel: rsp_valid with rsp_sine and rsp_cosine, signed, FRAC_BITS
// fraction bits, clamped to plus or minus one; the receiver drives rsp_stall.
// one result per angle, in order.
// throughput: one angle per cycle while req_stall is low.
// stages: 2*W wrap stages, W = 1 for FRAC_BITS >= 16, else 17 - FRAC_BITS,
// then the fold stage, one cell per iteration (at most TABLE_LEN), the output register.
// every stage is a register with its own valid bit; a stage holds only
// while it is full and the stage after it holds, so empty slots still close
// up while the receiver stalls, and req_stall rises only once the whole
// pipeline is full behind a stalled result.
// reset (synchronous) empties all stages; no clearing pass is needed.
module cordic_sine_cosine #(
   parameter int ITERATIONS = 16,
   parameter int FRAC_BITS  = 16
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        req_valid,
   input  logic signed [csc_pkg::ANGLE_WIDTH-1:0]      req_angle,
   output logic                                        req_stall,
   output logic                                        rsp_valid,
   output logic signed [csc_pkg::RESULT_WIDTH-1:0]     rsp_sine,
   output logic signed [csc_pkg::RESULT_WIDTH-1:0]     rsp_cosine,
   input  logic                                        rsp_stall
);
   import csc_pkg::*;

   localparam int N     = (ITERATIONS < TABLE_LEN) ? ITERATIONS : TABLE_LEN;
   localparam int SHIFT = WORK_BITS - FRAC_BITS;
   localparam int FW    = CW + 2;
   localparam logic signed [FW-1:0] HALF_LSB = FW'((64'd1 << SHIFT) >> 1);
   localparam logic signed [FW-1:0] ONE      = FW'(64'd1 << FRAC_BITS);

   csc_stage_type stage_w [N+1];
   logic          valid_w [N+1];
   logic          hold_w  [N+1];

   logic                           rsp_valid_ff;
   logic signed [RESULT_WIDTH-1:0] rsp_sine_ff;
   logic signed [RESULT_WIDTH-1:0] rsp_cosine_ff;
   logic signed [RESULT_WIDTH-1:0] rsp_sine_in;
   logic signed [RESULT_WIDTH-1:0] rsp_cosine_in;
   logic signed [FW-1:0]           sin_w;
   logic signed [FW-1:0]           cos_w;
   logic signed [FW-1:0]           sin_c;
   logic signed [FW-1:0]           cos_c;

   function automatic logic signed [FW-1:0] finish_value(input logic signed [FW-1:0] v);
      logic signed [FW-1:0] r;
      r = (v + HALF_LSB) >>> SHIFT;
      if (r > ONE) begin
         r = ONE;
      end else if (r < -ONE) begin
         r = -ONE;
      end
      return r;
   endfunction

   csc_reduce #(
      .FRAC_BITS (FRAC_BITS)
   ) u_reduce (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_angle  (req_angle),
      .in_hold   (req_stall),
      .out_valid (valid_w[0]),
      .out_stage (stage_w[0]),
      .out_hold  (hold_w[0])
   );

   genvar i;
   generate
      for (i = 0; i < N; i++) begin : g_cell
         csc_cell #(
            .STAGE (i)
         ) u_cell (
            .clock     (clock),
            .reset     (reset),
            .in_valid  (valid_w[i]),
            .in_stage  (stage_w[i]),
            .in_hold   (hold_w[i]),
            .out_valid (valid_w[i+1]),
            .out_stage (stage_w[i+1]),
            .out_hold  (hold_w[i+1])
         );
      end
   endgenerate

   assign hold_w[N] = rsp_valid_ff && rsp_stall;

   // rounding, cosine sign and clamp
   always_comb begin
      sin_w         = FW'(stage_w[N].y);
      cos_w         = stage_w[N].flip ? -FW'(stage_w[N].x) : FW'(stage_w[N].x);
      sin_c         = finish_value(sin_w);
      cos_c         = finish_value(cos_w);
      rsp_sine_in   = sin_c[RESULT_WIDTH-1:0];
      rsp_cosine_in = cos_c[RESULT_WIDTH-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (!hold_w[N]) begin
         rsp_valid_ff <= valid_w[N];
      end
   end

   always_ff @(posedge clock) begin
      if (!hold_w[N]) begin
         rsp_sine_ff   <= rsp_sine_in;
         rsp_cosine_ff <= rsp_cosine_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_sine   = rsp_sine_ff;
   assign rsp_cosine = rsp_cosine_ff;

endmodule

@@ hdl/csc_checker.sv @@
// port level checks of the cordic sine and cosine block, bound to the top level
// depends on cordic_sine_cosine_assert.svh and csc_pkg
`include "cordic_sine_cosine_assert.svh"

module csc_port_checks #(
   parameter int FRAC_BITS = 16
) (
   input logic                                        clock,
   input logic                                        reset,
   input logic                                        req_stall,
   input logic                                        rsp_valid,
   input logic signed [csc_pkg::RESULT_WIDTH-1:0]     rsp_sine,
   input logic signed [csc_pkg::RESULT_WIDTH-1:0]     rsp_cosine,
   input logic                                        rsp_stall
);
   import csc_pkg::*;

   localparam logic signed [RESULT_WIDTH-1:0] ONE_R = 18'sd65536;

   // a stalled result stays
   `CSC_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_sine) && $stable(rsp_cosine))

   // the input side is only stalled behind a stalled result
   `CSC_ASSERT_NOW(a_req_free, !rsp_valid || !rsp_stall, !req_stall)

   // results stay within plus or minus 65536 (one at FRAC_BITS 16), checked for FRAC_BITS up to 16
   `CSC_ASSERT_NOW(a_rsp_range, rsp_valid && (FRAC_BITS <= 16),
      rsp_sine <= ONE_R && rsp_sine >= -ONE_R && rsp_cosine <= ONE_R && rsp_cosine >= -ONE_R)

endmodule

bind cordic_sine_cosine csc_port_checks #(.FRAC_BITS(FRAC_BITS)) u_checker (.*);

@@ test/csc_checker.sv @@
`timescale 1ns / 100ps
// result checker for the cordic sine and cosine block: predicts sine and cosine
// of every accepted angle and compares each result transfer against it in order
// depends on csc_pkg for the port widths only
module csc_checker #(
   parameter int ITERATIONS = 16,
   parameter int FRAC_BITS  = 16
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   input  logic signed [csc_pkg::ANGLE_WIDTH-1:0]  req_angle,
   input  logic                                    req_stall,
   input  logic                                    rsp_valid,
   input  logic signed [csc_pkg::RESULT_WIDTH-1:0] rsp_sine,
   input  logic signed [csc_pkg::RESULT_WIDTH-1:0] rsp_cosine,
   input  logic                                    rsp_stall,
   output int                                      mismatch_count,
   output int                                      outstanding
);

   localparam int     WORK_FRAC   = 30;
   localparam int     ATAN_LEN    = 25;
   localparam longint PI_Q30      = 64'sd3373259426;
   localparam longint HALF_PI_Q30 = 64'sd1686629713;
   localparam longint TWO_PI_Q30  = 64'sd6746518852;
   localparam longint GAIN_Q30    = 64'sd652032874;

   typedef struct packed {
      logic signed [csc_pkg::RESULT_WIDTH-1:0] sine;
      logic signed [csc_pkg::RESULT_WIDTH-1:0] cosine;
   } trig_pair_type;

   trig_pair_type trig_expected[$];

   // atan(2^-i) in q2.30
   function automatic longint atan_step(int i);
      case (i)
         0:       return 64'sd843314857;
         1:       return 64'sd497837829;
         2:       return 64'sd263043837;
         3:       return 64'sd133525159;
         4:       return 64'sd67021687;
         5:       return 64'sd33543516;
         6:       return 64'sd16775851;
         7:       return 64'sd8388437;
         8:       return 64'sd4194283;
         9:       return 64'sd2097149;
         default: return 64'sd1 << (30 - i);
      endcase
   endfunction

   function automatic logic signed [csc_pkg::RESULT_WIDTH-1:0] round_clamp(longint v);
      longint unit;
      int     s;
      unit = 64'sd1 << FRAC_BITS;
      s = WORK_FRAC - FRAC_BITS;
      if (s > 0) begin
         v = (v + (64'sd1 << (s - 1))) >>> s;
      end
      if (v > unit) begin
         v = unit;
      end
      if (v < -unit) begin
         v = -unit;
      end
      return v[csc_pkg::RESULT_WIDTH-1:0];
   endfunction

   function automatic trig_pair_type predict_trig(logic signed [csc_pkg::ANGLE_WIDTH-1:0] angle);
      longint        a;
      longint        x;
      longint        y;
      longint        z;
      longint        dx;
      longint        dy;
      logic          flip;
      int            i;
      trig_pair_type r;
      a = longint'(angle) * (64'sd1 << (WORK_FRAC - FRAC_BITS));
      flip = 1'b0;
      while (a > PI_Q30) begin
         a -= TWO_PI_Q30;
      end
      while (a < -PI_Q30) begin
         a += TWO_PI_Q30;
      end
      // fold into the right half plane, cosine changes sign
      if (a > HALF_PI_Q30) begin
         a = PI_Q30 - a;
         flip = 1'b1;
      end else if (a < -HALF_PI_Q30) begin
         a = -PI_Q30 - a;
         flip = 1'b1;
      end
      x = GAIN_Q30;
      y = 0;
      z = a;
      for (i = 0; i < ITERATIONS && i < ATAN_LEN; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         // zero error steers clockwise
         if (z > 0) begin
            x -= dx;
            y += dy;
            z -= atan_step(i);
         end else begin
            x += dx;
            y -= dy;
            z += atan_step(i);
         end
      end
      if (flip) begin
         x = -x;
      end
      r.sine = round_clamp(y);
      r.cosine = round_clamp(x);
      return r;
   endfunction

   always @(posedge clock) begin
      trig_pair_type want;
      if (reset) begin
         trig_expected.delete();
         mismatch_count = 0;
      end else begin
         if (req_valid && !req_stall) begin
            trig_expected.push_back(predict_trig(req_angle));
         end
         if (rsp_valid && !rsp_stall) begin
            if (trig_expected.size() == 0) begin
               $error("result transfer with no angle outstanding: sine %0d, cosine %0d",
                      rsp_sine, rsp_cosine);
               mismatch_count++;
            end else begin
               want = trig_expected.pop_front();
               if (rsp_sine !== want.sine) begin
                  $error("sine: expected %0d, got %0d", want.sine, rsp_sine);
                  mismatch_count++;
               end
               if (rsp_cosine !== want.cosine) begin
                  $error("cosine: expected %0d, got %0d", want.cosine, rsp_cosine);
                  mismatch_count++;
               end
            end
         end
      end
      outstanding = trig_expected.size();
   end

endmodule

@@ test/tb_cordic_sine_cosine.sv @@
`timescale 1ns / 100ps
// testbench top for the cordic sine and cosine block: drives angles and result
// stalls through several idling phases and gives the verdict
// depends on csc_pkg, cordic_sine_cosine and csc_checker
module tb_cordic_sine_cosine;

   localparam int ITERATIONS = 16;
   localparam int FRAC_BITS  = 16;
   localparam int LATENCY    = 20;
   localparam int LONG_HOLD  = 80;
   localparam int PER_PHASE  = 265;

   logic                                    clock = 1'b0;
   logic                                    reset = 1'b1;
   logic                                    req_valid = 1'b0;
   logic signed [csc_pkg::ANGLE_WIDTH-1:0]  req_angle = '0;
   logic                                    req_stall;
   logic                                    rsp_valid;
   logic signed [csc_pkg::RESULT_WIDTH-1:0] rsp_sine;
   logic signed [csc_pkg::RESULT_WIDTH-1:0] rsp_cosine;
   logic                                    rsp_stall = 1'b0;
   int                                      mismatch_count;
   int                                      outstanding;

   int   send_idle_pct = 0;
   int   recv_stall_pct = 0;
   logic hold_pending = 1'b0;
   int   hold_left = 0;

   int directed_angles[$] = '{
      0, 1, -1, 524287, -524288, 411775, -411775, 411774, -411776,
      102943, 102944, -102943, -102944, 205887, 205888, -205887, -205888,
      308831, -308832, 51472, -51472, 65536, -65536, 12345
   };
   int phase_idle[4]  = '{0, 79, 0, 20};
   int phase_stall[4] = '{0, 0, 79, 20};

   cordic_sine_cosine #(
      .ITERATIONS(ITERATIONS),
      .FRAC_BITS (FRAC_BITS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_angle (req_angle),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_sine  (rsp_sine),
      .rsp_cosine(rsp_cosine),
      .rsp_stall (rsp_stall)
   );

   csc_checker #(
      .ITERATIONS(ITERATIONS),
      .FRAC_BITS (FRAC_BITS)
   ) checker_i (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_angle     (req_angle),
      .req_stall     (req_stall),
      .rsp_valid     (rsp_valid),
      .rsp_sine      (rsp_sine),
      .rsp_cosine    (rsp_cosine),
      .rsp_stall     (rsp_stall),
      .mismatch_count(mismatch_count),
      .outstanding   (outstanding)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // result side: random stalls, or a long hold counted here
   always @(negedge clock) begin
      if (hold_pending) begin
         hold_left = LONG_HOLD;
         hold_pending = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
      end
   end

   function automatic logic signed [csc_pkg::ANGLE_WIDTH-1:0] random_angle();
      if ($urandom_range(0, 3) != 0) begin
         return csc_pkg::ANGLE_WIDTH'(int'($urandom_range(0, 823550)) - 411775);
      end
      return csc_pkg::ANGLE_WIDTH'($urandom);
   endfunction

   // called and returns at a falling edge
   task automatic send_angle(input logic signed [csc_pkg::ANGLE_WIDTH-1:0] angle);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_angle <= angle;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic pause_until_drained();
      req_valid <= 1'b0;
      wait (outstanding == 0);
      @(negedge clock);
   endtask

   initial begin
      int p;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      foreach (directed_angles[k]) begin
         send_angle(csc_pkg::ANGLE_WIDTH'(directed_angles[k]));
      end
      for (p = 0; p < 4; p++) begin
         send_idle_pct = phase_idle[p];
         recv_stall_pct = phase_stall[p];
         repeat (PER_PHASE) send_angle(random_angle());
      end
      // long result hold while angles keep coming, so the pipeline backs up
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_pending = 1'b1;
      repeat (60) send_angle(random_angle());
      pause_until_drained();
      send_idle_pct = 20;
      recv_stall_pct = 20;
      repeat (40) send_angle(random_angle());
      pause_until_drained();
      repeat (LATENCY + 10) @(posedge clock);
      if (mismatch_count == 0 && outstanding == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
